FILE: rtl/pte_pkg.sv
// ----------------------------------------------------------------------------
// Piece table editor package
// Shared constants, codes and types of the piece table editor.
// ----------------------------------------------------------------------------
package pte_pkg;

	localparam int MaxPiecesDefault = 64;
	localparam int PosBitsDefault   = 32;
	localparam int FieldBits        = 32;
	localparam int CountBits        = 7;
	localparam int MaxResults       = 64;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_DUMP   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_IGNORED  = 3'd1,
		ST_FULL     = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// Command that every cell sees in the same cycle.
	typedef enum logic [3:0] {
		CC_HOLD   = 4'd0,
		CC_RELOAD = 4'd1,
		CC_SHR    = 4'd2, // take left neighbour when index > key
		CC_SHL    = 4'd3, // take right neighbour when index >= key
		CC_WRITE  = 4'd4, // load cell key with the write piece
		CC_ROTATE = 4'd5  // take right neighbour everywhere (dump walk)
	} cell_cmd_t;

endpackage

FILE: rtl/pte_cell.sv
// ----------------------------------------------------------------------------
// Piece table cell
// Holds one piece descriptor and moves it to or from its neighbours.
// ----------------------------------------------------------------------------
module pte_cell #(
	parameter int POS_BITS = pte_pkg::PosBitsDefault,
	parameter int IDX_BITS = 6
) (
	input  logic                    clk,
	input  pte_pkg::cell_cmd_t      cmd,
	input  logic [IDX_BITS-1:0]     my_idx,
	input  logic [IDX_BITS-1:0]     key,
	input  logic                    first,
	input  logic [POS_BITS-1:0]     reload_len,
	input  logic                    wr_src,
	input  logic [POS_BITS-1:0]     wr_start,
	input  logic [POS_BITS-1:0]     wr_len,
	input  logic                    lt_src,
	input  logic [POS_BITS-1:0]     lt_start,
	input  logic [POS_BITS-1:0]     lt_len,
	input  logic                    rt_src,
	input  logic [POS_BITS-1:0]     rt_start,
	input  logic [POS_BITS-1:0]     rt_len,
	output logic                    src_q,
	output logic [POS_BITS-1:0]     start_q,
	output logic [POS_BITS-1:0]     len_q
);
	import pte_pkg::*;

	// Update the descriptor from the shared command
	always_ff @(posedge clk) begin
		unique case (cmd)
			CC_RELOAD: begin
				src_q   <= 1'b0;
				start_q <= '0;
				len_q   <= first ? reload_len : '0;
			end
			CC_SHR: if (my_idx > key) begin
				src_q <= lt_src; start_q <= lt_start; len_q <= lt_len;
			end
			CC_SHL: if (my_idx >= key) begin
				src_q <= rt_src; start_q <= rt_start; len_q <= rt_len;
			end
			CC_WRITE: if (my_idx == key) begin
				src_q <= wr_src; start_q <= wr_start; len_q <= wr_len;
			end
			CC_ROTATE: begin
				src_q <= rt_src; start_q <= rt_start; len_q <= rt_len;
			end
			default: ;
		endcase
	end
endmodule

FILE: rtl/piece_table_editor_core.sv
// ----------------------------------------------------------------------------
// Piece table editor core
// Ordered table of piece descriptors held in a chain of cells.
// ----------------------------------------------------------------------------
// The table lives in a row of MAX_PIECES cells that shift one place per cycle
// towards either neighbour. One item is worked on at a time. A dump rotates the
// whole row once past cell 0 and gives one result per pass through S_DWAIT,
// S_OUT and S_ROT, waiting in S_OUT while the receiver is not ready. An insert
// or remove scans the entries one per cycle to find the covering pieces, then
// moves the tail by one place per cycle and writes the new pieces. A
// configuration write reloads the table in the next cycle. Nothing is
// reset-only: after reset the row is reloaded in the first cycle before any
// item is taken.
module piece_table_editor_core #(
	parameter int MAX_PIECES = pte_pkg::MaxPiecesDefault,
	parameter int POS_BITS   = pte_pkg::PosBitsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: opcode[1:0], position[33:2], length_or_end[65:34], zero fill
	input  logic [71:0]  s_tdata,
	input  logic         m_tready,
	output logic         m_tvalid,
	// tdata: status[2:0], doc_length[34:3], piece_count[41:35],
	//        piece_source[42], piece_start[74:43], piece_length[106:75], fill
	output logic [111:0] m_tdata,
	output logic         m_tlast
);
	import pte_pkg::*;

	localparam int IB = $clog2(MAX_PIECES);
	localparam int CB = $clog2(MAX_PIECES + 3);
	localparam logic [CB-1:0] MaxCnt = CB'(MAX_PIECES);
	localparam logic [CB-1:0] MaxRes = (MAX_PIECES > MaxResults) ?
		CB'(MaxResults) : CB'(MAX_PIECES);

	typedef enum logic [9:0] {
		S_INIT  = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_SCAN  = 10'b0000000100,
		S_PLAN  = 10'b0000001000,
		S_SHIFT = 10'b0000010000,
		S_WRITE = 10'b0000100000,
		S_DUMP  = 10'b0001000000,
		S_DWAIT = 10'b0010000000,
		S_OUT   = 10'b0100000000,
		S_ROT   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [POS_BITS-1:0] orig_q, doc_q, fill_q;
	logic [CB-1:0]       cnt_q;
	opcode_t             op_q;
	logic [POS_BITS-1:0] a_q, b_q, end_q;
	logic [CB-1:0]       scan_q;     // entry being scanned
	logic [POS_BITS:0]   off_q;      // running offset
	logic                si_f_q, ei_f_q;
	logic [IB-1:0]       si_q, ei_q;
	logic [POS_BITS-1:0] soff_q, eoff_q;
	logic                si_src_q, ei_src_q;
	logic [POS_BITS-1:0] si_st_q, si_len_q, ei_st_q, ei_len_q;
	logic [CB-1:0]       steps_q;    // shift steps left
	logic                dir_q;      // 1 right, 0 left
	logic [IB-1:0]       key_q;
	logic [1:0]          nw_q, wi_q; // new pieces, written so far
	logic                np_src_q [3];
	logic [POS_BITS-1:0] np_st_q [3];
	logic [POS_BITS-1:0] np_len_q [3];
	logic [CB-1:0]       rot_q;
	logic [2:0]          ost_q;
	logic                opsrc_q;
	logic [POS_BITS-1:0] opst_q, oplen_q;
	logic                olast_q;

	cell_cmd_t           cmd;
	logic [IB-1:0]       key;
	logic                c_src [MAX_PIECES];
	logic [POS_BITS-1:0] c_st  [MAX_PIECES];
	logic [POS_BITS-1:0] c_len [MAX_PIECES];

	// Build the chain; the right end wraps to cell 0 for the dump rotation
	for (genvar g = 0; g < MAX_PIECES; g++) begin : g_cell
		localparam int L = (g == 0) ? 0 : g - 1;
		localparam int R = (g == MAX_PIECES - 1) ? 0 : g + 1;
		pte_cell #(.POS_BITS(POS_BITS), .IDX_BITS(IB)) u_cell (
			.clk(clk), .cmd(cmd), .my_idx(IB'(g)), .key(key), .first(g == 0),
			.reload_len(orig_q),
			.wr_src(np_src_q[wi_q]), .wr_start(np_st_q[wi_q]),
			.wr_len(np_len_q[wi_q]),
			.lt_src(c_src[L]), .lt_start(c_st[L]), .lt_len(c_len[L]),
			.rt_src(c_src[R]), .rt_start(c_st[R]), .rt_len(c_len[R]),
			.src_q(c_src[g]), .start_q(c_st[g]), .len_q(c_len[g])
		);
	end

	// Select the scanned entry; found pieces are captured into registers
	logic                sc_src;
	logic [POS_BITS-1:0] sc_st, sc_len;
	logic [IB-1:0]       sidx;
	assign sidx   = scan_q[IB-1:0];
	assign sc_src = c_src[sidx];
	assign sc_st  = c_st[sidx];
	assign sc_len = c_len[sidx];

	logic [POS_BITS:0] nxt_off;
	assign nxt_off = off_q + {1'b0, sc_len};

	assign cfg_ready = (state_q == S_IDLE);
	assign s_tready  = (state_q == S_IDLE) && !cfg_valid;
	assign m_tvalid  = (state_q == S_OUT);
	assign m_tlast   = olast_q;
	assign m_tdata   = {5'd0, FieldBits'(oplen_q), FieldBits'(opst_q), opsrc_q,
		CountBits'(cnt_q), FieldBits'(doc_q), ost_q};

	// Cell command
	always_comb begin
		cmd = CC_HOLD;
		key = key_q;
		unique case (state_q)
			S_INIT:  cmd = CC_RELOAD;
			S_SHIFT: if (steps_q != '0) cmd = dir_q ? CC_SHR : CC_SHL;
			S_WRITE: if (wi_q != nw_q) cmd = CC_WRITE;
			S_ROT:   cmd = CC_ROTATE;
			default: ;
		endcase
	end

	logic [POS_BITS:0]   add_sum, doc_sum;
	logic [POS_BITS-1:0] idx_c, rest_c, cut_c;
	logic [CB-1:0]       nrem_c, nnew_c;

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			orig_q  <= '0;
			doc_q   <= '0;
			fill_q  <= '0;
			cnt_q   <= CB'(1);
			olast_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					doc_q <= orig_q; fill_q <= '0; cnt_q <= CB'(1);
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cfg_valid) begin
						orig_q <= POS_BITS'(cfg_data);
						state_q <= S_INIT;
					end else if (s_tvalid) begin
						op_q  <= opcode_t'(s_tdata[1:0]);
						a_q   <= POS_BITS'(s_tdata[33:2]);
						b_q   <= POS_BITS'(s_tdata[65:34]);
						end_q <= (POS_BITS'(s_tdata[65:34]) < doc_q) ?
							POS_BITS'(s_tdata[65:34]) : doc_q;
						scan_q <= '0; off_q <= '0;
						si_f_q <= 1'b0; ei_f_q <= 1'b0;
						opsrc_q <= 1'b0; opst_q <= '0; oplen_q <= '0;
						olast_q <= 1'b1;
						unique case (opcode_t'(s_tdata[1:0]))
							OP_DUMP:   state_q <= S_DUMP;
							OP_NONE: begin ost_q <= ST_IGNORED; state_q <= S_OUT; end
							default:   state_q <= S_SCAN;
						endcase
					end
				end
				S_SCAN: begin
					// Validate on the first cycle, then walk entries
					if (scan_q == '0 && !si_f_q && !ei_f_q && off_q == '0 &&
						op_q == OP_INSERT && b_q == '0) begin
						ost_q <= ST_IGNORED; state_q <= S_OUT;
					end else if (scan_q == '0 && off_q == '0 && !si_f_q &&
						op_q == OP_REMOVE && (a_q >= doc_q || a_q >= b_q)) begin
						ost_q <= ST_IGNORED; state_q <= S_OUT;
					end else if (scan_q >= cnt_q) begin
						state_q <= S_PLAN;
					end else begin
						// Positions searched: insert idx / remove start, and end-1
						if (!si_f_q && ({1'b0, idx_c} < nxt_off)) begin
							si_f_q <= 1'b1; si_q <= sidx; soff_q <= off_q[POS_BITS-1:0];
							si_src_q <= sc_src; si_st_q <= sc_st; si_len_q <= sc_len;
						end
						if (!ei_f_q && ({1'b0, end_q} < nxt_off + 1'b1) &&
							end_q != '0) begin
							ei_f_q <= 1'b1; ei_q <= sidx; eoff_q <= off_q[POS_BITS-1:0];
							ei_src_q <= sc_src; ei_st_q <= sc_st; ei_len_q <= sc_len;
						end
						off_q  <= nxt_off;
						scan_q <= scan_q + 1'b1;
					end
				end
				S_PLAN: begin
					ost_q <= ST_DONE;
					state_q <= S_SHIFT;
					wi_q <= '0;
					if (op_q == OP_INSERT) begin
						np_src_q[0] <= 1'b1; np_st_q[0] <= fill_q; np_len_q[0] <= b_q;
						if (add_sum[POS_BITS] || doc_sum[POS_BITS]) begin
							ost_q <= ST_OVERFLOW; state_q <= S_OUT;
						end else if (cnt_q == '0 || idx_c == doc_q) begin
							if (cnt_q + 1'b1 > MaxCnt) begin
								ost_q <= ST_FULL; state_q <= S_OUT;
							end else begin
								key_q <= cnt_q[IB-1:0]; nw_q <= 2'd1; steps_q <= '0;
								cnt_q <= cnt_q + 1'b1;
							end
						end else if (!si_f_q) begin
							ost_q <= ST_IGNORED; state_q <= S_OUT;
						end else if (idx_c != soff_q) begin
							if (cnt_q + 2'd2 > MaxCnt) begin
								ost_q <= ST_FULL; state_q <= S_OUT;
							end else begin
								np_src_q[0] <= si_src_q; np_st_q[0] <= si_st_q;
								np_len_q[0] <= idx_c - soff_q;
								np_src_q[1] <= 1'b1; np_st_q[1] <= fill_q; np_len_q[1] <= b_q;
								np_src_q[2] <= si_src_q;
								np_st_q[2] <= si_st_q + (idx_c - soff_q);
								np_len_q[2] <= si_len_q - (idx_c - soff_q);
								nw_q <= 2'd3; dir_q <= 1'b1; key_q <= si_q;
								steps_q <= CB'(2);
								cnt_q <= cnt_q + 2'd2;
							end
						end else begin
							if (cnt_q + 1'b1 > MaxCnt) begin
								ost_q <= ST_FULL; state_q <= S_OUT;
							end else begin
								nw_q <= 2'd1; dir_q <= 1'b1; key_q <= si_q;
								steps_q <= CB'(1);
								cnt_q <= cnt_q + 1'b1;
							end
						end
					end else begin
						if (!si_f_q || !ei_f_q || ei_q < si_q) begin
							ost_q <= ST_IGNORED; state_q <= S_OUT;
						end else if (cnt_q - nrem_c + nnew_c > MaxCnt) begin
							ost_q <= ST_FULL; state_q <= S_OUT;
						end else begin
							key_q <= si_q;
							if (a_q != soff_q) begin
								np_src_q[0] <= si_src_q; np_st_q[0] <= si_st_q;
								np_len_q[0] <= a_q - soff_q;
								np_src_q[1] <= ei_src_q; np_st_q[1] <= ei_st_q + cut_c;
								np_len_q[1] <= rest_c;
							end else begin
								np_src_q[0] <= ei_src_q; np_st_q[0] <= ei_st_q + cut_c;
								np_len_q[0] <= rest_c;
							end
							nw_q <= nnew_c[1:0];
							if (nnew_c > nrem_c) begin
								dir_q <= 1'b1; steps_q <= nnew_c - nrem_c;
							end else begin
								dir_q <= 1'b0; steps_q <= nrem_c - nnew_c;
							end
							cnt_q <= cnt_q - nrem_c + nnew_c;
							doc_q <= doc_q - (end_q - a_q);
						end
					end
				end
				S_SHIFT: begin
					if (steps_q == '0) state_q <= S_WRITE;
					else steps_q <= steps_q - 1'b1;
				end
				S_WRITE: begin
					if (wi_q == nw_q) begin
						if (op_q == OP_INSERT) begin
							doc_q  <= doc_sum[POS_BITS-1:0];
							fill_q <= add_sum[POS_BITS-1:0];
						end
						state_q <= S_OUT;
					end else begin
						wi_q <= wi_q + 1'b1; key_q <= key_q + 1'b1;
					end
				end
				S_DUMP: begin
					rot_q <= '0;
					if (cnt_q == '0) begin
						ost_q <= ST_EMPTY; olast_q <= 1'b1; state_q <= S_OUT;
					end else begin
						ost_q <= ST_DONE;
						state_q <= S_DWAIT;
					end
				end
				S_DWAIT: begin
					// Present cell 0 as the next dumped piece
					opsrc_q <= c_src[0]; opst_q <= c_st[0]; oplen_q <= c_len[0];
					olast_q <= (rot_q + 1'b1 == ((cnt_q > MaxRes) ? MaxRes : cnt_q));
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) begin
						if (op_q == OP_DUMP && ost_q == ST_DONE) state_q <= S_ROT;
						else state_q <= S_IDLE;
					end
				end
				S_ROT: begin
					// Rotate the row; after a full turn the table is back in place
					rot_q <= rot_q + 1'b1;
					if (rot_q == MaxCnt - 1'b1) state_q <= S_IDLE;
					else if (rot_q + 1'b1 < ((cnt_q > MaxRes) ? MaxRes : cnt_q))
						state_q <= S_DWAIT;
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	// Edit arithmetic
	always_comb begin
		idx_c   = (op_q == OP_INSERT) ? ((a_q < doc_q) ? a_q : doc_q) : a_q;
		add_sum = {1'b0, fill_q} + {1'b0, b_q};
		doc_sum = {1'b0, doc_q} + {1'b0, b_q};
		cut_c   = end_q - eoff_q;
		rest_c  = ei_len_q - cut_c;
		nrem_c  = CB'(ei_q) - CB'(si_q) + 1'b1;
		nnew_c  = CB'(a_q != soff_q) + CB'(rest_c != '0);
	end
endmodule

FILE: rtl/pte_checker.sv
// ----------------------------------------------------------------------------
// Piece table editor port checker
// Checks the output handshake and sequencing at the top level ports.
// ----------------------------------------------------------------------------
module pte_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [111:0] m_tdata,
	input logic         m_tlast,
	input logic         cfg_ready
);
	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");
	// No new item while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("item taken during output");
	// Drop ready after an input transfer
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("second item taken");
	// Status stays within its codes
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd4) else $error("bad status");
	// Configuration only when idle
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !m_tvalid) else $error("config while busy");
endmodule

bind piece_table_editor_core pte_checker u_pte_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tlast(m_tlast), .cfg_ready(cfg_ready)
);
